/* sv/hrbl_pkg.sv */
package hrbl_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_STAT_SKIP  = 4'd0,
        PH_STAT_CMP   = 4'd1,
        PH_STAT_EOL   = 4'd2,
        PH_HDR_START  = 4'd3,
        PH_HDR_CR     = 4'd4,
        PH_NAME       = 4'd5,
        PH_SPACE      = 4'd6,
        PH_VALUE      = 4'd7,
        PH_COOKIE     = 4'd8,
        PH_SKIP_LINE  = 4'd9,
        PH_CHUNK_SIZE = 4'd10,
        PH_SIZE_EOL   = 4'd11,
        PH_CHUNK_DATA = 4'd12,
        PH_DATA_EOL   = 4'd13,
        PH_BODY       = 4'd14,
        PH_DONE       = 4'd15
    } phase_t;

    // Result item kinds.
    typedef enum logic [2:0] {
        KIND_COOKIE_BYTE = 3'd0,
        KIND_COOKIE_END  = 3'd1,
        KIND_STATUS_BAD  = 3'd2,
        KIND_LENGTH_DONE = 3'd3,
        KIND_EARLY_END   = 3'd4
    } kind_t;

    // Operations of the string matcher.
    typedef enum logic [2:0] {
        MOP_HOLD       = 3'd0,
        MOP_START      = 3'd1,
        MOP_START_C    = 3'd2,
        MOP_STATUS     = 3'd3,
        MOP_NAME_FIRST = 3'd4,
        MOP_NAME       = 3'd5,
        MOP_VALUE      = 3'd6,
        MOP_SET        = 3'd7
    } match_op_t;

    localparam int unsigned MATCH_IDX_BITS = 5;
    localparam int unsigned CAND_BITS      = 3;

    // Candidate slots: A is the status text or Transfer-Encoding,
    // B is Set-Cookie, C is the chunked value.
    localparam int unsigned CAND_A = 0;
    localparam int unsigned CAND_B = 1;
    localparam int unsigned CAND_C = 2;

    localparam logic [MATCH_IDX_BITS-1:0] LEN_STATUS  = 5'd6;
    localparam logic [MATCH_IDX_BITS-1:0] LEN_TE      = 5'd17;
    localparam logic [MATCH_IDX_BITS-1:0] LEN_SC      = 5'd10;
    localparam logic [MATCH_IDX_BITS-1:0] LEN_CHUNKED = 5'd7;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        match_op_t            op;
        logic [CAND_BITS-1:0] set_alive;
    } match_cmd_t;

    typedef struct packed {
        logic full_status;
        logic full_te;
        logic full_sc;
        logic full_chunked;
        logic alive_a;
        logic alive_b;
    } match_stat_t;

endpackage

/* sv/http_response_body_length_parser.sv */
// Channel  | Direction | Ports                                                   | Moves
// s_       | in        | s_valid s_ready s_action s_data_byte                    | one item per byte
// m_       | out       | m_valid m_ready m_kind m_cookie_byte m_body_length      | zero or one item
//          |           | m_cookie_count                                          |   per input item
//
// An input item is captured in an input register and processed once the output register is
// free; its result, if any, is registered in the output register and leaves on m_ready.
// One item per cycle is sustained while m_ready stays high.
// aresetn is synchronous and active low; it returns the parser to the status-line search.
// A stalled result holds the output register; the input register still takes one more item,
// and s_ready drops only while both registers are full and m_ready is low.
module http_response_body_length_parser #(
    parameter int unsigned LENGTH_BITS = 32,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_cookie_byte,
    output logic [31:0] m_body_length,
    output logic [15:0] m_cookie_count
);
    import hrbl_pkg::*;

    // Input register stage.
    logic       in_valid_reg;
    logic       action_reg;
    logic [7:0] byte_reg;

    // Output register stage.
    logic        m_valid_reg;
    kind_t       m_kind_reg;
    logic [7:0]  m_cookie_byte_reg;
    logic [31:0] m_body_length_reg;
    logic [15:0] m_cookie_count_reg;

    // Parser state.
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   chunked_reg;
    logic                   chunked_next;
    logic [LENGTH_BITS-1:0] hex_reg;
    logic [LENGTH_BITS-1:0] hex_next;
    logic                   hex_stopped_reg;
    logic                   hex_stopped_next;
    logic [LENGTH_BITS-1:0] skip_reg;
    logic [LENGTH_BITS-1:0] skip_next;
    logic [LENGTH_BITS-1:0] body_sum_reg;
    logic [LENGTH_BITS-1:0] body_sum_next;
    logic [COUNT_BITS-1:0]  cookies_reg;
    logic [COUNT_BITS-1:0]  cookies_next;

    logic        out_free;
    logic        proc;
    match_cmd_t  mcmd;
    match_stat_t mstat;

    // Result of the item being processed.
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_cookie;
    logic       res_with_len;

    // Helper arithmetic.
    logic                   hex_ok;
    logic [3:0]             hex_dig;
    logic [LENGTH_BITS:0]   sum_wide;
    logic [LENGTH_BITS-1:0] skip_dec;
    logic [LENGTH_BITS+31:0] len_ext;
    logic [COUNT_BITS+15:0]  cnt_ext;

    // The output register is free when empty or being drained this cycle; the item in the
    // input register is processed exactly when its result (if any) has a place to go.
    assign out_free = !m_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            byte_reg   <= s_data_byte;
        end
    end

    // Hex digit decode for chunk size lines.
    always_comb begin
        hex_ok  = 1'b1;
        hex_dig = 4'd0;
        if (byte_reg >= "0" && byte_reg <= "9") begin
            hex_dig = 4'(byte_reg - "0");
        end else if (byte_reg >= "a" && byte_reg <= "f") begin
            hex_dig = 4'(byte_reg - "a" + 8'd10);
        end else if (byte_reg >= "A" && byte_reg <= "F") begin
            hex_dig = 4'(byte_reg - "A" + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign sum_wide = {1'b0, body_sum_reg} + {1'b0, hex_reg};
    assign skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

    // Next-state logic.
    always_comb begin
        phase_next       = phase_reg;
        chunked_next     = chunked_reg;
        hex_next         = hex_reg;
        hex_stopped_next = hex_stopped_reg;
        skip_next        = skip_reg;
        body_sum_next    = body_sum_reg;
        cookies_next     = cookies_reg;
        mcmd.op          = MOP_HOLD;
        mcmd.set_alive   = '0;

        if (phase_reg != PH_DONE) begin
            if (action_reg) begin
                // End of stream closes the parse wherever it happens.
                phase_next = PH_DONE;
            end else begin
                unique case (phase_reg)
                    PH_STAT_SKIP: begin
                        if (byte_reg == CH_SPACE) begin
                            mcmd.op    = MOP_START;
                            phase_next = PH_STAT_CMP;
                        end
                    end
                    PH_STAT_CMP: begin
                        if (byte_reg == CH_CR) begin
                            phase_next = mstat.full_status ? PH_STAT_EOL : PH_DONE;
                        end else begin
                            mcmd.op = MOP_STATUS;
                        end
                    end
                    PH_STAT_EOL, PH_SKIP_LINE: begin
                        if (byte_reg == CH_LF) begin
                            phase_next = PH_HDR_START;
                        end
                    end
                    PH_HDR_START, PH_HDR_CR: begin
                        if (phase_reg == PH_HDR_START && byte_reg == CH_CR) begin
                            phase_next = PH_HDR_CR;
                        end else if (phase_reg == PH_HDR_CR && byte_reg == CH_LF) begin
                            // Blank line: the body starts.
                            if (chunked_reg) begin
                                hex_next         = '0;
                                hex_stopped_next = 1'b0;
                                phase_next       = PH_CHUNK_SIZE;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end else if (byte_reg == CH_COLON) begin
                            // An empty header name matches nothing.
                            mcmd.op    = MOP_SET;
                            phase_next = PH_SPACE;
                        end else begin
                            mcmd.op    = MOP_NAME_FIRST;
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (byte_reg == CH_COLON) begin
                            mcmd.op = MOP_SET;
                            if (mstat.full_te) begin
                                mcmd.set_alive[CAND_A] = 1'b1;
                            end else if (mstat.full_sc) begin
                                mcmd.set_alive[CAND_B] = 1'b1;
                            end
                            phase_next = PH_SPACE;
                        end else begin
                            mcmd.op = MOP_NAME;
                        end
                    end
                    PH_SPACE: begin
                        // The byte after the colon is skipped whatever it is.
                        if (mstat.alive_a) begin
                            mcmd.op    = MOP_START_C;
                            phase_next = PH_VALUE;
                        end else if (mstat.alive_b) begin
                            phase_next = PH_COOKIE;
                        end else begin
                            phase_next = PH_SKIP_LINE;
                        end
                    end
                    PH_VALUE: begin
                        if (byte_reg == CH_CR) begin
                            if (mstat.full_chunked) begin
                                chunked_next = 1'b1;
                            end
                            phase_next = PH_SKIP_LINE;
                        end else begin
                            mcmd.op = MOP_VALUE;
                        end
                    end
                    PH_COOKIE: begin
                        if (byte_reg == CH_CR || byte_reg == CH_SEMI) begin
                            if (cookies_reg != '1) begin
                                cookies_next = cookies_reg + 1'b1;
                            end
                            phase_next = PH_SKIP_LINE;
                        end
                    end
                    PH_CHUNK_SIZE: begin
                        if (byte_reg == CH_CR) begin
                            phase_next = PH_SIZE_EOL;
                        end else if (hex_stopped_reg || !hex_ok) begin
                            hex_stopped_next = 1'b1;
                        end else if (hex_reg[LENGTH_BITS-1 -: 4] != 4'd0) begin
                            hex_next = '1;
                        end else begin
                            hex_next = {hex_reg[LENGTH_BITS-5:0], hex_dig};
                        end
                    end
                    PH_SIZE_EOL: begin
                        if (byte_reg == CH_LF) begin
                            if (hex_reg == '0) begin
                                phase_next = PH_DONE;
                            end else begin
                                body_sum_next = sum_wide[LENGTH_BITS] ? '1
                                                : sum_wide[LENGTH_BITS-1:0];
                                skip_next     = hex_reg;
                                phase_next    = PH_CHUNK_DATA;
                            end
                        end
                    end
                    PH_CHUNK_DATA: begin
                        skip_next = skip_dec;
                        if (skip_dec == '0) begin
                            phase_next = PH_DATA_EOL;
                        end
                    end
                    PH_DATA_EOL: begin
                        if (byte_reg == CH_LF) begin
                            hex_next         = '0;
                            hex_stopped_next = 1'b0;
                            phase_next       = PH_CHUNK_SIZE;
                        end
                    end
                    PH_BODY: begin
                        if (body_sum_reg != '1) begin
                            body_sum_next = body_sum_reg + 1'b1;
                        end
                    end
                    PH_DONE: begin
                    end
                endcase
            end
        end
    end

    // Result logic.
    always_comb begin
        res_valid    = 1'b0;
        res_kind     = KIND_COOKIE_BYTE;
        res_cookie   = 8'd0;
        res_with_len = 1'b0;
        if (phase_reg != PH_DONE) begin
            if (action_reg) begin
                res_valid    = 1'b1;
                res_kind     = (phase_reg == PH_BODY) ? KIND_LENGTH_DONE : KIND_EARLY_END;
                res_with_len = 1'b1;
            end else begin
                priority if (phase_reg == PH_STAT_CMP) begin
                    if (byte_reg == CH_CR && !mstat.full_status) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_STATUS_BAD;
                    end
                end else if (phase_reg == PH_COOKIE) begin
                    res_valid = 1'b1;
                    if (byte_reg == CH_CR || byte_reg == CH_SEMI) begin
                        res_kind = KIND_COOKIE_END;
                    end else begin
                        res_kind   = KIND_COOKIE_BYTE;
                        res_cookie = byte_reg;
                    end
                end else if (phase_reg == PH_SIZE_EOL) begin
                    if (byte_reg == CH_LF && hex_reg == '0) begin
                        res_valid    = 1'b1;
                        res_kind     = KIND_LENGTH_DONE;
                        res_with_len = 1'b1;
                    end
                end else begin
                    res_valid = 1'b0;
                end
            end
        end
    end

    // Fit the running sums to the fixed result field widths.
    assign len_ext = {32'd0, body_sum_reg};
    assign cnt_ext = {16'd0, cookies_next};

    hrbl_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (proc),
        .cmd       (mcmd),
        .data_byte (byte_reg),
        .stat      (mstat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_STAT_SKIP;
            chunked_reg     <= 1'b0;
            hex_reg         <= '0;
            hex_stopped_reg <= 1'b0;
            skip_reg        <= '0;
            body_sum_reg    <= '0;
            cookies_reg     <= '0;
        end else if (proc) begin
            phase_reg       <= phase_next;
            chunked_reg     <= chunked_next;
            hex_reg         <= hex_next;
            hex_stopped_reg <= hex_stopped_next;
            skip_reg        <= skip_next;
            body_sum_reg    <= body_sum_next;
            cookies_reg     <= cookies_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_valid) begin
            m_kind_reg         <= res_kind;
            m_cookie_byte_reg  <= res_cookie;
            m_body_length_reg  <= res_with_len ? len_ext[31:0] : 32'd0;
            m_cookie_count_reg <= cnt_ext[15:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_cookie_byte  = m_cookie_byte_reg;
    assign m_body_length  = m_body_length_reg;
    assign m_cookie_count = m_cookie_count_reg;

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled while a register was free");

    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("parser left the done phase without reset");

    a_final_kind_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && res_valid && (res_kind == KIND_STATUS_BAD || res_kind == KIND_LENGTH_DONE ||
        res_kind == KIND_EARLY_END) |=> phase_reg == PH_DONE)
        else $error("final result did not end the parse");

    a_cookies_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> cookies_reg >= $past(cookies_reg))
        else $error("cookie count decreased");

endmodule

/* sv/hrbl_match.sv */
module hrbl_match (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  hrbl_pkg::match_cmd_t cmd,
    input  logic [7:0]           data_byte,
    output hrbl_pkg::match_stat_t stat
);
    import hrbl_pkg::*;

    logic [MATCH_IDX_BITS-1:0] idx_reg;
    logic [MATCH_IDX_BITS-1:0] idx_next;
    logic [CAND_BITS-1:0]      alive_reg;
    logic [CAND_BITS-1:0]      alive_next;
    logic [MATCH_IDX_BITS-1:0] idx_eff;
    logic [CAND_BITS-1:0]      alive_eff;
    logic [MATCH_IDX_BITS-1:0] idx_adv;
    logic                      hit_status;
    logic                      hit_te;
    logic                      hit_sc;
    logic                      hit_chunked;

    function automatic logic [7:0] status_char(input logic [MATCH_IDX_BITS-1:0] i);
        logic [7:0] c;
        unique case (i)
            5'd0:    c = "2";
            5'd1:    c = "0";
            5'd2:    c = "0";
            5'd3:    c = " ";
            5'd4:    c = "O";
            5'd5:    c = "K";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] te_char(input logic [MATCH_IDX_BITS-1:0] i);
        logic [7:0] c;
        unique case (i)
            5'd0:    c = "T";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "E";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sc_char(input logic [MATCH_IDX_BITS-1:0] i);
        logic [7:0] c;
        unique case (i)
            5'd0:    c = "S";
            5'd1:    c = "e";
            5'd2:    c = "t";
            5'd3:    c = "-";
            5'd4:    c = "C";
            5'd5:    c = "o";
            5'd6:    c = "o";
            5'd7:    c = "k";
            5'd8:    c = "i";
            5'd9:    c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] chunked_char(input logic [MATCH_IDX_BITS-1:0] i);
        logic [7:0] c;
        unique case (i)
            5'd0:    c = "c";
            5'd1:    c = "h";
            5'd2:    c = "u";
            5'd3:    c = "n";
            5'd4:    c = "k";
            5'd5:    c = "e";
            5'd6:    c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // The first name byte starts a fresh match in the same cycle.
    assign idx_eff   = (cmd.op == MOP_NAME_FIRST) ? '0 : idx_reg;
    assign alive_eff = (cmd.op == MOP_NAME_FIRST) ? '1 : alive_reg;
    assign idx_adv   = (idx_eff != '1) ? idx_eff + 1'b1 : idx_eff;

    assign hit_status  = (idx_eff < LEN_STATUS)  && (status_char(idx_eff) == data_byte);
    assign hit_te      = (idx_eff < LEN_TE)      && (te_char(idx_eff) == data_byte);
    assign hit_sc      = (idx_eff < LEN_SC)      && (sc_char(idx_eff) == data_byte);
    assign hit_chunked = (idx_eff < LEN_CHUNKED) && (chunked_char(idx_eff) == data_byte);

    always_comb begin
        idx_next   = idx_reg;
        alive_next = alive_reg;
        unique case (cmd.op)
            MOP_HOLD: begin
            end
            MOP_START: begin
                idx_next   = '0;
                alive_next = '1;
            end
            MOP_START_C: begin
                idx_next           = '0;
                alive_next         = '0;
                alive_next[CAND_C] = 1'b1;
            end
            MOP_STATUS: begin
                alive_next[CAND_A] = alive_eff[CAND_A] & hit_status;
                idx_next           = idx_adv;
            end
            MOP_NAME_FIRST, MOP_NAME: begin
                alive_next         = alive_eff;
                alive_next[CAND_A] = alive_eff[CAND_A] & hit_te;
                alive_next[CAND_B] = alive_eff[CAND_B] & hit_sc;
                idx_next           = idx_adv;
            end
            MOP_VALUE: begin
                alive_next[CAND_C] = alive_eff[CAND_C] & hit_chunked;
                idx_next           = idx_adv;
            end
            MOP_SET: begin
                alive_next = cmd.set_alive;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            alive_reg <= '1;
        end else if (en) begin
            idx_reg   <= idx_next;
            alive_reg <= alive_next;
        end
    end

    assign stat.full_status  = alive_reg[CAND_A] && (idx_reg == LEN_STATUS);
    assign stat.full_te      = alive_reg[CAND_A] && (idx_reg == LEN_TE);
    assign stat.full_sc      = alive_reg[CAND_B] && (idx_reg == LEN_SC);
    assign stat.full_chunked = alive_reg[CAND_C] && (idx_reg == LEN_CHUNKED);
    assign stat.alive_a      = alive_reg[CAND_A];
    assign stat.alive_b      = alive_reg[CAND_B];

    a_start_all_alive: assert property (@(posedge aclk) disable iff (!aresetn)
        en && (cmd.op == MOP_START) |=> (alive_reg == '1) && (idx_reg == '0))
        else $error("matcher start did not revive all candidates");

    a_start_c_only: assert property (@(posedge aclk) disable iff (!aresetn)
        en && (cmd.op == MOP_START_C) |=> (alive_reg == 3'b100) && (idx_reg == '0))
        else $error("value match did not start with only the chunked candidate");

    a_index_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg == '1) && en && (cmd.op == MOP_NAME || cmd.op == MOP_VALUE ||
        cmd.op == MOP_STATUS) |=> (idx_reg == '1))
        else $error("match index wrapped");

    a_names_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.full_te && stat.full_sc) && !(stat.full_status && stat.full_chunked))
        else $error("two candidate lengths matched at once");

endmodule
